>>> rtl/core/lrw_pkg.sv
// Package with constants, register indexes and beat types for the lattice random walk step.
package lrw_pkg;

    localparam int COORD_BITS = 16;
    localparam int COUNT_BITS = 40;
    localparam int SIZE_BITS  = COORD_BITS + 1;
    localparam int LATTICE_W  = 17;
    localparam int SEED_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED     = 1'b1;

    localparam logic [LATTICE_W-1:0] LATTICE_RESET = 17'd512;
    localparam logic [SEED_W-1:0]    SEED_RESET    = 32'd1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } t_in_beat;

    typedef struct packed {
        logic [COORD_BITS-1:0] new_x;
        logic [COORD_BITS-1:0] new_y;
        logic                  in_center;
        logic [COUNT_BITS-1:0] center_hits;
    } t_out_beat;

    typedef struct packed {
        logic move_x;
        logic up;
    } t_step_ctl;

endpackage

>>> rtl/core/lrw_gen.sv
// Shift-xor generator of the 32-bit random word, with seed load and advance.
module lrw_gen (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_seed_we,
    input  logic [lrw_pkg::SEED_W-1:0]    i_seed,
    input  logic                          i_advance,
    output lrw_pkg::t_step_ctl            o_ctl
);

    logic [lrw_pkg::SEED_W-1:0] r_word;
    logic [lrw_pkg::SEED_W-1:0] n_word;
    logic [lrw_pkg::SEED_W-1:0] w1;
    logic [lrw_pkg::SEED_W-1:0] w2;
    logic [lrw_pkg::SEED_W-1:0] adv;

    always_comb begin
        w1  = r_word ^ (r_word << 7);
        w2  = w1 ^ lrw_pkg::SEED_W'($signed(w1) >>> 9);
        adv = w2 ^ (w2 << 8);
    end

    always_comb begin
        n_word = r_word;
        if (i_seed_we) begin
            n_word = i_seed;
        end else if (i_advance) begin
            n_word = adv;
        end
    end

    assign o_ctl.move_x = adv[0];
    assign o_ctl.up     = adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= lrw_pkg::SEED_RESET;
        end else begin
            r_word <= n_word;
        end
    end

endmodule

>>> rtl/core/lrw_calc.sv
// Step logic: size clamp, coordinate saturation, wrapped move and central half-square test.
module lrw_calc (
    input  logic [lrw_pkg::LATTICE_W-1:0]  i_lattice_size,
    input  lrw_pkg::t_in_beat              i_pos,
    input  lrw_pkg::t_step_ctl             i_ctl,
    output logic [lrw_pkg::COORD_BITS-1:0] o_new_x,
    output logic [lrw_pkg::COORD_BITS-1:0] o_new_y,
    output logic                           o_center
);

    localparam int SB = lrw_pkg::SIZE_BITS;
    localparam int CMP_BITS = (SB > lrw_pkg::LATTICE_W) ? SB : lrw_pkg::LATTICE_W;
    localparam int HB = SB + 2;
    localparam logic [CMP_BITS-1:0] SIZE_TOP = CMP_BITS'(1) << lrw_pkg::COORD_BITS;
    localparam logic [CMP_BITS-1:0] SIZE_MIN = CMP_BITS'(2);

    logic [CMP_BITS-1:0] size_w;
    logic [SB-1:0]       size;
    logic [SB-1:0]       x0;
    logic [SB-1:0]       y0;
    logic [SB-1:0]       v;
    logic [SB-1:0]       v_moved;
    logic [SB-1:0]       x1;
    logic [SB-1:0]       y1;
    logic [SB-1:0]       lo;
    logic [HB-1:0]       hi3;
    logic [SB-1:0]       hi;

    always_comb begin
        size_w = CMP_BITS'(i_lattice_size);
        if (size_w > SIZE_TOP) begin
            size_w = SIZE_TOP;
        end else if (size_w < SIZE_MIN) begin
            size_w = SIZE_MIN;
        end
        size = size_w[SB-1:0];

        x0 = SB'(i_pos.pos_x);
        y0 = SB'(i_pos.pos_y);
        if (x0 >= size) begin
            x0 = size - SB'(1);
        end
        if (y0 >= size) begin
            y0 = size - SB'(1);
        end

        v = i_ctl.move_x ? x0 : y0;
        if (i_ctl.up) begin
            v_moved = ((v + SB'(1)) >= size) ? SB'(0) : v + SB'(1);
        end else begin
            v_moved = (v == SB'(0)) ? size - SB'(1) : v - SB'(1);
        end
        x1 = i_ctl.move_x ? v_moved : x0;
        y1 = i_ctl.move_x ? y0 : v_moved;

        lo  = size >> 2;
        hi3 = ((HB'(size) << 1) + HB'(size)) >> 2;
        hi  = hi3[SB-1:0];
        o_center = (x1 >= lo) && (x1 < hi) && (y1 >= lo) && (y1 < hi);
        o_new_x  = x1[lrw_pkg::COORD_BITS-1:0];
        o_new_y  = y1[lrw_pkg::COORD_BITS-1:0];
    end

endmodule

>>> rtl/core/lattice_random_walk_step.sv
// Top level of the lattice random walk step: input register, step logic and result register.
// A beat is held in the input register, passes the combinational step logic, then is held in
// the result register. One beat per cycle is taken while the output is not stalled.
// Reset (synchronous, active low) empties both stages, sets lattice size to 512,
// loads the generator word with 1 and clears the central hit count.
module lattice_random_walk_step (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lrw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lrw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  lrw_pkg::t_in_beat                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output lrw_pkg::t_out_beat                 o_out_data
);

    logic [lrw_pkg::LATTICE_W-1:0]  r_lattice_size;
    logic                           r_s1_valid;
    lrw_pkg::t_in_beat              r_s1_pos;
    lrw_pkg::t_step_ctl             r_s1_ctl;
    logic                           r_out_valid;
    lrw_pkg::t_out_beat             r_out_data;
    logic [lrw_pkg::COUNT_BITS-1:0] r_hits;
    logic [lrw_pkg::COUNT_BITS-1:0] n_hits;

    logic                           s1_adv;
    logic                           in_accept;
    logic                           seed_we;
    lrw_pkg::t_step_ctl             gen_ctl;
    logic [lrw_pkg::COORD_BITS-1:0] calc_x;
    logic [lrw_pkg::COORD_BITS-1:0] calc_y;
    logic                           calc_center;

    assign s1_adv     = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign seed_we    = i_cfg_we && (i_cfg_idx == lrw_pkg::CFG_RNG_SEED);

    lrw_gen u_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed_we (seed_we),
        .i_seed    (i_cfg_data[lrw_pkg::SEED_W-1:0]),
        .i_advance (in_accept),
        .o_ctl     (gen_ctl)
    );

    lrw_calc u_calc (
        .i_lattice_size (r_lattice_size),
        .i_pos          (r_s1_pos),
        .i_ctl          (r_s1_ctl),
        .o_new_x        (calc_x),
        .o_new_y        (calc_y),
        .o_center       (calc_center)
    );

    always_comb begin
        n_hits = r_hits;
        if (calc_center && (r_hits != lrw_pkg::COUNT_MAX)) begin
            n_hits = r_hits + lrw_pkg::COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lattice_size <= lrw_pkg::LATTICE_RESET;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_hits         <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == lrw_pkg::CFG_LATTICE_SIZE)) begin
                r_lattice_size <= i_cfg_data[lrw_pkg::LATTICE_W-1:0];
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_hits <= n_hits;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pos <= i_in_data;
            r_s1_ctl <= gen_ctl;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_data.new_x       <= calc_x;
            r_out_data.new_y       <= calc_y;
            r_out_data.in_center   <= calc_center;
            r_out_data.center_hits <= n_hits;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
